// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expands to one labeled concurrent assertion clocked on i_clk
// and disabled while i_rst_n is low; synthesis sees nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/pdc_pkg.sv
`timescale 1ns / 1ps

package pdc_pkg;

    // Sample and field widths
    localparam int SAMPLE_BITS = 10;
    localparam int TARGET_W    = 10;
    localparam int GAIN_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DUTY_W      = 10;
    localparam int CLAMP_W     = 2;
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DUTY_W + 7) / 8) * 8;

    // Datapath widths
    localparam int ERR_W  = SAMPLE_BITS + 1;       // target - height
    localparam int DIFF_W = ERR_W + 1;             // prev_error - error
    localparam int ACC_W  = 32;                    // Q16.16 integral
    localparam int MA_W   = GAIN_W + 1;            // gain or zero-extended step
    localparam int PROD_W = MA_W + ACC_W;          // shared multiplier product
    localparam int SUM_W  = SAMPLE_BITS + 17;      // P + I + D, no wrap

    localparam int DUTY_MAX = (1 << DUTY_W) - 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 3'd0,
        CFG_GAIN_P = 3'd1,
        CFG_GAIN_I = 3'd2,
        CFG_GAIN_D = 3'd3,
        CFG_STEP   = 3'd4
    } t_cfg_idx;

    // Clamp codes on the result
    typedef enum logic [CLAMP_W-1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } t_clamp;

    // Shared multiplier operand select
    typedef enum logic [1:0] {
        MUL_STEP,
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    // Term accumulator operation
    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_LOAD_P,
        SUM_ADD_I,
        SUM_ADD_D
    } t_sum_op;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MSTEP,
        ST_ACC,
        ST_MP,
        ST_MI,
        ST_MD,
        ST_SUMD,
        ST_OUT
    } t_state;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [GAIN_W-1:0]   step;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic     ld_sample;
        logic     ld_err;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ld_acc;
        t_sum_op  sum_op;
        logic     ld_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

    // Target masked to the sample width
    function automatic logic [SAMPLE_BITS-1:0] mask_target(input logic [TARGET_W-1:0] t);
        logic [SAMPLE_BITS-1:0] res;
        res = '0;
        for (int k = 0; k < SAMPLE_BITS; k++) begin
            if (k < TARGET_W) begin
                res[k] = t[k];
            end
        end
        return res;
    endfunction

endpackage

// File: sv/pdc_ctrl.sv
`timescale 1ns / 1ps

module pdc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pdc_pkg::t_dp_stat i_stat,
    output pdc_pkg::t_dp_cmd  o_cmd
);
    import pdc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_STEP;
        o_cmd.sum_op  = SUM_HOLD;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.ld_sample = 1'b1;
                    n_state         = ST_ERR;
                end
            end
            ST_ERR: begin
                o_cmd.ld_err = 1'b1;
                n_state      = ST_MSTEP;
            end
            ST_MSTEP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_STEP;
                n_state       = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.ld_acc = 1'b1;
                n_state      = ST_MP;
            end
            ST_MP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P;
                n_state       = ST_MI;
            end
            ST_MI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_I;
                o_cmd.sum_op  = SUM_LOAD_P;
                n_state       = ST_MD;
            end
            ST_MD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_D;
                o_cmd.sum_op  = SUM_ADD_I;
                n_state       = ST_SUMD;
            end
            ST_SUMD: begin
                o_cmd.sum_op = SUM_ADD_D;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!i_stat.out_busy) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/pdc_datapath.sv
`timescale 1ns / 1ps

module pdc_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pdc_pkg::t_cfg                   i_cfg,
    input  logic [pdc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  pdc_pkg::t_dp_cmd                i_cmd,
    output pdc_pkg::t_dp_stat               o_stat,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [pdc_pkg::DUTY_W-1:0]      o_duty,
    output logic [pdc_pkg::CLAMP_W-1:0]     o_clamp
);
    import pdc_pkg::*;

    localparam logic signed [PROD_W-1:0] ACC_HI =
        {{(PROD_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [PROD_W-1:0] ACC_LO =
        {{(PROD_W - ACC_W + 1){1'b1}}, {(ACC_W - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_DUTY_MAX = SUM_W'(DUTY_MAX);

    // Toward-zero division of a product by 2^8 and 2^24
    function automatic logic signed [SUM_W-1:0] trunc_q8(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] biased;
        logic signed [PROD_W-1:0] shifted;
        biased  = p + (p[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
        shifted = biased >>> 8;
        return shifted[SUM_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] trunc_q24(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] biased;
        logic signed [PROD_W-1:0] shifted;
        biased  = p + (p[PROD_W-1] ? PROD_W'(24'hFF_FFFF) : PROD_W'(0));
        shifted = biased >>> 24;
        return shifted[SUM_W-1:0];
    endfunction

    logic [SAMPLE_BITS-1:0]    r_height;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [ERR_W-1:0]   r_prev;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_out_valid;
    logic [DUTY_W-1:0]         r_duty;
    logic [CLAMP_W-1:0]        r_clamp;

    logic signed [ERR_W-1:0]   w_err;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [MA_W-1:0]    w_mul_a;
    logic signed [ACC_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_acc_sum;
    logic signed [SUM_W-1:0]   w_sum_add;
    logic [DUTY_W-1:0]         w_duty;
    t_clamp                    w_clamp;

    // Error and difference from the captured sample
    assign w_err  = $signed({1'b0, mask_target(i_cfg.target)}) - $signed({1'b0, r_height});
    assign w_diff = $signed({r_prev[ERR_W-1], r_prev}) - $signed({w_err[ERR_W-1], w_err});

    // Shared multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_STEP: begin
                w_mul_a = $signed({1'b0, i_cfg.step});
                w_mul_b = $signed({{(ACC_W - ERR_W){r_err[ERR_W-1]}}, r_err});
            end
            MUL_P: begin
                w_mul_a = $signed({i_cfg.gain_p[GAIN_W-1], i_cfg.gain_p});
                w_mul_b = $signed({{(ACC_W - ERR_W){r_err[ERR_W-1]}}, r_err});
            end
            MUL_I: begin
                w_mul_a = $signed({i_cfg.gain_i[GAIN_W-1], i_cfg.gain_i});
                w_mul_b = r_acc;
            end
            MUL_D: begin
                w_mul_a = $signed({i_cfg.gain_d[GAIN_W-1], i_cfg.gain_d});
                w_mul_b = $signed({{(ACC_W - DIFF_W){r_diff[DIFF_W-1]}}, r_diff});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod    = w_mul_a * w_mul_b;
    assign w_acc_sum = $signed({{(PROD_W - ACC_W){r_acc[ACC_W-1]}}, r_acc}) + r_prod;

    // Term selection for the running sum
    always_comb begin
        case (i_cmd.sum_op)
            SUM_LOAD_P: w_sum_add = trunc_q8(r_prod);
            SUM_ADD_I:  w_sum_add = r_sum + trunc_q24(r_prod);
            SUM_ADD_D:  w_sum_add = r_sum + trunc_q8(r_prod);
            default:    w_sum_add = r_sum;
        endcase
    end

    // Output clamp
    always_comb begin
        if (r_sum > SUM_DUTY_MAX) begin
            w_duty  = DUTY_W'(DUTY_MAX);
            w_clamp = CLAMP_HIGH;
        end else if (r_sum[SUM_W-1]) begin
            w_duty  = '0;
            w_clamp = CLAMP_LOW;
        end else begin
            w_duty  = r_sum[DUTY_W-1:0];
            w_clamp = CLAMP_NONE;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_sample) begin
            r_height <= i_sample;
        end
        if (i_cmd.ld_err) begin
            r_err  <= w_err;
            r_diff <= w_diff;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        r_sum <= w_sum_add;
        if (i_cmd.ld_out) begin
            r_duty  <= w_duty;
            r_clamp <= w_clamp;
        end
    end

    // Controller state carried between words: integral and last error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_prev <= '0;
        end else begin
            if (i_cmd.ld_err) begin
                r_prev <= w_err;
            end
            if (i_cmd.ld_acc) begin
                if (w_acc_sum > ACC_HI) begin
                    r_acc <= ACC_HI[ACC_W-1:0];
                end else if (w_acc_sum < ACC_LO) begin
                    r_acc <= ACC_LO[ACC_W-1:0];
                end else begin
                    r_acc <= w_acc_sum[ACC_W-1:0];
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_duty          = r_duty;
    assign o_clamp         = r_clamp;

endmodule

// File: sv/pid_duty_cycle_controller_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                          Contents
// --------  ---------  -----------------------------  ------------------------------------
// sample    in         s_axis_tvalid/tready/tdata     tdata[9:0] height_sample
// result    out        m_axis_tvalid/tready/tdata/    tdata[9:0] duty,
//                      tuser                          tuser[1:0] clamp_state
// config    in         i_cfg_valid/o_cfg_ready/       index 0..4, data[15:0]
//                      i_cfg_index/i_cfg_data
//
// Each sample word steps through ERR, MSTEP, ACC, MP, MI, MD, SUMD and OUT: one
// shared 17x32 multiplier forms error*step, P, I and D in turn.
// A new sample is taken once the previous result is loaded; the result waits
// in its own register meanwhile. A stalled result stream holds the sequencer
// in its final step. Reset is synchronous: integral and last error clear,
// gains return to defaults. Config writes are always ready.
`include "assert_macros.svh"

module pid_duty_cycle_controller_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample input
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [pdc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // [9:0] height_sample
    // result output
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [pdc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // [9:0] duty
    output logic [pdc_pkg::CLAMP_W-1:0]          m_axis_tuser,   // [1:0] clamp_state
    // config write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import pdc_pkg::*;

    logic [TARGET_W-1:0] r_target;
    logic [GAIN_W-1:0]   r_gain_p;
    logic [GAIN_W-1:0]   r_gain_i;
    logic [GAIN_W-1:0]   r_gain_d;
    logic [GAIN_W-1:0]   r_step;

    t_cfg                w_cfg;
    t_dp_cmd             w_cmd;
    t_dp_stat            w_stat;
    logic [DUTY_W-1:0]   w_duty;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_W'(50);
            r_gain_p <= GAIN_W'(230);
            r_gain_i <= GAIN_W'(1152);
            r_gain_d <= '0;
            r_step   <= GAIN_W'(33);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET: r_target <= i_cfg_data[TARGET_W-1:0];
                CFG_GAIN_P: r_gain_p <= i_cfg_data;
                CFG_GAIN_I: r_gain_i <= i_cfg_data;
                CFG_GAIN_D: r_gain_d <= i_cfg_data;
                CFG_STEP:   r_step   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.target = r_target;
    assign w_cfg.gain_p = r_gain_p;
    assign w_cfg.gain_i = r_gain_i;
    assign w_cfg.gain_d = r_gain_d;
    assign w_cfg.step   = r_step;

    // Sequencer
    pdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and result register
    pdc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_duty     (w_duty),
        .o_clamp    (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - DUTY_W){1'b0}}, w_duty};

    // A sample never produces its result in the cycle after acceptance
    `ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready, !w_cmd.ld_out, "result loaded right after accept")
    // The result register is only loaded when free
    `ASSERT_IMPLIES(a_load_free, w_cmd.ld_out, !m_axis_tvalid || m_axis_tready, "result overwritten while stalled")
    // Clamp code agrees with the duty value
    `ASSERT_IMPLIES(a_clamp_high, m_axis_tvalid && (m_axis_tuser == CLAMP_HIGH), w_duty == DUTY_W'(DUTY_MAX), "high clamp without full duty")
    `ASSERT_IMPLIES(a_clamp_low, m_axis_tvalid && (m_axis_tuser == CLAMP_LOW), w_duty == '0, "low clamp with nonzero duty")

endmodule

// File: tb/tb_pid_duty_cycle_controller_top.sv
`timescale 1ns / 1ps

module tb_pid_duty_cycle_controller_top;
    import pdc_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_SETTLE = 12;     // cycles after the last result before a setting write
    localparam int SINK_HOLD    = 300;    // long result back-pressure stretch
    localparam int END_SETTLE   = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int CFG_IDX_TOP  = (1 << CFG_IDX_W) - 1;
    localparam longint ACC_HI   = (64'sd1 <<< 31) - 1;
    localparam longint ACC_LO   = -(64'sd1 <<< 31);

    typedef enum {
        OP_SAMPLE,
        OP_CONFIG,
        OP_DRAIN,
        OP_SINK_HOLD
    } t_op_kind;

    typedef struct {
        t_op_kind               kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
        int                     gap;
    } t_tb_op;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        t_clamp            clamp;
    } t_duty_result;

    // DUT ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic [CLAMP_W-1:0]         m_axis_tuser;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    pid_duty_cycle_controller_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock and reset
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Controller shadow: settings and loop state
    logic [TARGET_W-1:0]        set_target = 10'd50;
    logic signed [GAIN_W-1:0]   set_gain_p = 16'sd230;
    logic signed [GAIN_W-1:0]   set_gain_i = 16'sd1152;
    logic signed [GAIN_W-1:0]   set_gain_d = 16'sd0;
    logic [GAIN_W-1:0]          set_step   = 16'd33;
    longint                     integ_q    = 0;
    longint                     last_err   = 0;

    t_duty_result   duty_expected[$];
    t_tb_op         pending_ops[$];

    int  mismatches   = 0;
    int  samples_sent = 0;
    int  results_seen = 0;
    int  cfg_writes   = 0;
    int  sat_hits     = 0;
    int  clamp_hits[3] = '{0, 0, 0};
    int  hold_reqs    = 0;
    logic stim_done   = 1'b0;

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d (result %0d, t=%0t)",
                 what, got, want, results_seen, $time);
        mismatches++;
    endtask

    function automatic void load_setting(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_TARGET: set_target = value[TARGET_W-1:0];
            CFG_GAIN_P: set_gain_p = value;
            CFG_GAIN_I: set_gain_i = value;
            CFG_GAIN_D: set_gain_d = value;
            CFG_STEP:   set_step   = value;
            default: ;  // unused index, write dropped
        endcase
    endfunction

    // One control tick: error, saturating integral, P + I + D, output clamp
    function automatic void predict_duty(input logic [SAMPLE_BITS-1:0] height);
        longint       err;
        longint       acc;
        longint       diff;
        longint       total;
        t_duty_result res;
        err = longint'(set_target[SAMPLE_BITS-1:0]) - longint'(height);
        acc = integ_q + err * longint'(set_step);
        if (acc > ACC_HI) begin
            acc = ACC_HI;
            sat_hits++;
        end else if (acc < ACC_LO) begin
            acc = ACC_LO;
            sat_hits++;
        end
        integ_q  = acc;
        diff     = last_err - err;
        last_err = err;
        // signed division truncates toward zero
        total = (longint'(set_gain_p) * err) / 256
              + (longint'(set_gain_i) * acc) / 16777216
              + (longint'(set_gain_d) * diff) / 256;
        if (total > DUTY_MAX) begin
            res.duty  = DUTY_W'(DUTY_MAX);
            res.clamp = CLAMP_HIGH;
        end else if (total < 0) begin
            res.duty  = '0;
            res.clamp = CLAMP_LOW;
        end else begin
            res.duty  = DUTY_W'(total);
            res.clamp = CLAMP_NONE;
        end
        duty_expected.push_back(res);
    endfunction

    // Stimulus program builders
    task automatic queue_sample(input int h, input int gap);
        t_tb_op op;
        op.kind  = OP_SAMPLE;
        op.index = '0;
        op.data  = CFG_DATA_W'(h);
        op.gap   = gap;
        pending_ops.push_back(op);
    endtask

    task automatic queue_cfg(input int idx, input logic [CFG_DATA_W-1:0] value);
        t_tb_op op;
        op.kind  = OP_CONFIG;
        op.index = CFG_IDX_W'(idx);
        op.data  = value;
        op.gap   = $urandom_range(0, 3);
        pending_ops.push_back(op);
    endtask

    task automatic queue_marker(input t_op_kind kind);
        t_tb_op op;
        op.kind  = kind;
        op.index = '0;
        op.data  = '0;
        op.gap   = DRAIN_SETTLE;
        pending_ops.push_back(op);
    endtask

    initial begin : build_stimulus
        logic [CFG_DATA_W-1:0] value;
        int n, mode, level, h, burst, phase, tgt_shadow, random_items;
        int dir_heights[7] = '{0, 1023, 50, 49, 51, 512, 1023};

        // Directed: reset settings, sample extremes and zero error
        foreach (dir_heights[k]) queue_sample(dir_heights[k], $urandom_range(0, 6));

        // Directed: gain and step extremes, wide target, unused index
        queue_marker(OP_DRAIN);
        queue_cfg(CFG_TARGET, 16'hFC00 | CFG_DATA_W'(DUTY_MAX));
        queue_cfg(CFG_GAIN_P, 16'h7FFF);
        queue_cfg(CFG_GAIN_I, 16'h8000);
        queue_cfg(CFG_GAIN_D, 16'h7FFF);
        queue_cfg(CFG_STEP, 16'hFFFF);
        queue_cfg(CFG_IDX_TOP, 16'hFFFF);
        for (int k = 0; k < 6; k++) queue_sample((k % 2) ? 1023 : 0, $urandom_range(0, 6));

        queue_marker(OP_DRAIN);
        queue_cfg(CFG_TARGET, 16'h0000);
        queue_cfg(CFG_GAIN_P, 16'h8000);
        queue_cfg(CFG_GAIN_I, 16'h7FFF);
        queue_cfg(CFG_GAIN_D, 16'h8000);
        queue_cfg(CFG_STEP, 16'h0000);
        queue_cfg(int'(CFG_STEP) + 1, 16'h5555);
        queue_sample(0, 0);
        queue_sample(1023, 0);
        queue_sample(0, 0);
        tgt_shadow = 0;

        // Random phases: new settings, then a shaped height sequence
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            queue_marker(OP_DRAIN);
            for (int r = 0; r <= int'(CFG_STEP); r++) begin
                if (phase == 0 || $urandom_range(0, 1)) begin
                    value = CFG_DATA_W'($urandom);
                    case ($urandom_range(0, 5))
                        0: value = 16'h7FFF;
                        1: value = 16'h8000;
                        2: value = 16'hFFFF;
                        3: value = 16'h0000;
                        default: value = CFG_DATA_W'($signed(value) >>> $urandom_range(0, 13));
                    endcase
                    if (r == int'(CFG_TARGET)) tgt_shadow = value[TARGET_W-1:0];
                    queue_cfg(r, value);
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                queue_cfg($urandom_range(int'(CFG_STEP) + 1, CFG_IDX_TOP), CFG_DATA_W'($urandom));
            end

            n     = $urandom_range(20, 120);
            mode  = $urandom_range(0, 3);
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) level = $urandom_range(0, 1023);
            else level = $urandom_range(0, 1) ? 1023 : 0;
            // long result stall while samples keep coming
            if (phase == 2 || phase == 9) begin
                queue_marker(OP_SINK_HOLD);
                burst = 1;
            end
            for (int k = 0; k < n; k++) begin
                case (mode)
                    0: h = $urandom_range(0, 1023);
                    1: h = level;  // steady offset walks the integral to its limits
                    2: begin
                        // heights within 8 of the target give small errors
                        h = tgt_shadow + $urandom_range(0, 16) - 8;
                        if (h < 0) h = 0;
                        if (h > 1023) h = 1023;
                    end
                    default: h = (k % 3 == 0) ? (1023 - level) : ((level + k * 37) % 1024);
                endcase
                queue_sample(h, burst ? 0 : $urandom_range(0, 6));
                random_items++;
            end
            phase++;
        end
    end

    // Driver: works through the pending program
    logic   drv_active = 1'b0;
    t_tb_op cur_op;
    int     wait_left = 0;

    always @(posedge i_clk) begin
        logic sv_valid;
        logic cv_valid;
        sv_valid = s_axis_tvalid;
        cv_valid = i_cfg_valid;
        if (i_rst_n) begin
            // completed words
            if (s_axis_tvalid && s_axis_tready) begin
                predict_duty(cur_op.data[SAMPLE_BITS-1:0]);
                samples_sent++;
                sv_valid   = 1'b0;
                drv_active = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                load_setting(cur_op.index, cur_op.data);
                cfg_writes++;
                cv_valid   = 1'b0;
                drv_active = 1'b0;
            end
            // next operation
            if (!drv_active && pending_ops.size() > 0) begin
                cur_op     = pending_ops.pop_front();
                wait_left  = cur_op.gap;
                drv_active = 1'b1;
            end
            if (drv_active && !sv_valid && !cv_valid) begin
                case (cur_op.kind)
                    OP_SAMPLE: begin
                        if (wait_left > 0) begin
                            wait_left--;
                        end else begin
                            sv_valid = 1'b1;
                            s_axis_tdata <= IN_TDATA_W'(cur_op.data[SAMPLE_BITS-1:0]);
                        end
                    end
                    OP_CONFIG: begin
                        if (wait_left > 0) begin
                            wait_left--;
                        end else begin
                            cv_valid = 1'b1;
                            i_cfg_index <= cur_op.index;
                            i_cfg_data  <= cur_op.data;
                        end
                    end
                    OP_DRAIN: begin
                        if (results_seen == samples_sent) begin
                            if (wait_left > 0) wait_left--;
                            else drv_active = 1'b0;
                        end
                    end
                    default: begin
                        hold_reqs  <= hold_reqs + 1;
                        drv_active = 1'b0;
                    end
                endcase
            end
            if (!drv_active && pending_ops.size() == 0) stim_done <= 1'b1;
        end
        s_axis_tvalid <= sv_valid;
        i_cfg_valid   <= cv_valid;
    end

    // Monitor: result stall pattern and field checks
    int   sink_wait = 0;
    int   hold_left = 0;
    int   hold_seen = 0;
    int   result_count = 0;
    logic sink_calm = 1'b0;

    always @(posedge i_clk) begin
        logic         rdy;
        t_duty_result want;
        rdy = m_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen <= results_seen + 1;
                result_count++;
                if (duty_expected.size() == 0) begin
                    flag_mismatch("unexpected word, duty", m_axis_tdata, -1);
                end else begin
                    want = duty_expected.pop_front();
                    if (m_axis_tdata !== OUT_TDATA_W'(want.duty))
                        flag_mismatch("duty", m_axis_tdata, want.duty);
                    if (m_axis_tuser !== want.clamp)
                        flag_mismatch("clamp_state", m_axis_tuser, want.clamp);
                    clamp_hits[int'(want.clamp)]++;
                end
                if (result_count % 100 == 0) sink_calm = ($urandom_range(0, 2) == 0);
                sink_wait = sink_calm ? 0 : $urandom_range(0, 6);
                rdy = 1'b0;
            end
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = SINK_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!rdy) begin
                if (sink_wait > 0) sink_wait--;
                else rdy = 1'b1;
            end
        end
        m_axis_tready <= rdy;
    end

    // Watchdog
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, duty_expected.size());
            $display("FAIL pid_duty_cycle_controller_top");
            $finish;
        end
    end

    // End of run
    initial begin
        wait (stim_done);
        wait (results_seen == samples_sent);
        repeat (END_SETTLE) @(posedge i_clk);
        if (duty_expected.size() != 0)
            flag_mismatch("results never delivered", 0, duty_expected.size());
        $display("Ran %0d samples through %0d setting writes, %0d integral saturations.",
                 samples_sent, cfg_writes, sat_hits);
        $display("Duty in range %0d, clamped high %0d, clamped low %0d.",
                 clamp_hits[int'(CLAMP_NONE)], clamp_hits[int'(CLAMP_HIGH)],
                 clamp_hits[int'(CLAMP_LOW)]);
        if (mismatches == 0) begin
            $display("PASS pid_duty_cycle_controller_top");
        end else begin
            $display("FAIL pid_duty_cycle_controller_top");
        end
        $finish;
    end

endmodule
